// ----- rtl/lcam_pkg.sv -----
// Shared types, widths and codes for the loop current level alarm monitor.
package lcam_pkg;

   localparam int ADC_W = 12;
   localparam int ACT_W = 14;
   localparam int CSR_W = 14;
   localparam int CSR_INDEX_W = 3;
   localparam int MODE_W = 2;

   localparam int DEFAULT_FULL_SCALE_CODE = 4095;
   localparam int DEFAULT_ACTIVITY_SCALE = 10000;

   localparam logic [ACT_W-1:0] LEVEL_RESET = ACT_W'(10000);

   localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DIGITAL = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ANALOG = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SENSOR_MODE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALARM_MASK = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALARM_LEVEL = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UPPER_LEVEL = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HYSTERESIS = 3'd4;

   typedef enum logic [1:0] {
      KIND_VALUE = 2'd0,
      KIND_LOW   = 2'd1,
      KIND_HIGH  = 2'd2,
      KIND_COMMS = 2'd3
   } kind_type;

   // One sample after range checks and scaling, ready for the state update.
   typedef struct packed {
      logic             loop_low;
      logic             loop_high;
      logic             ana_ok;
      logic [ACT_W-1:0] ana_val;
      logic             comms_ok;
      logic [ACT_W-1:0] comms;
      logic             startup;
      logic             lost;
   } tick_type;

endpackage

// ----- rtl/lcam_scale.sv -----
// Range compares and loop current to activity scaling behind the input register.
module lcam_scale #(
   parameter int FULL_SCALE_CODE = lcam_pkg::DEFAULT_FULL_SCALE_CODE,
   parameter int ACTIVITY_SCALE = lcam_pkg::DEFAULT_ACTIVITY_SCALE
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [lcam_pkg::ADC_W-1:0]   in_adc,
   input  logic [lcam_pkg::ACT_W-1:0]   in_comms,
   input  logic                         in_startup,
   input  logic                         in_lost,
   output logic                         out_valid,
   input  logic                         out_ready,
   output lcam_pkg::tick_type           out_tick
);
   import lcam_pkg::*;

   localparam longint unsigned FS = longint'(FULL_SCALE_CODE);
   localparam longint unsigned AS = longint'(ACTIVITY_SCALE);
   localparam longint unsigned ADC_MAX = (longint'(1) << ADC_W) - 1;
   localparam int CMP_W = $clog2(21 * FS + 20 * ADC_MAX + 1);
   localparam longint unsigned DIV = 4 * FS;
   localparam int NUM_W = $clog2(DIV + 1);
   // Scale over the divisor, rounded up, with enough fraction bits that the
   // quotient is exact for every numerator up to the divisor.
   localparam int SHIFT = $clog2(DIV * DIV);
   localparam longint unsigned MUL = ((AS << SHIFT) + DIV - 1) / DIV;
   localparam int M_W = $clog2(MUL + 1);
   localparam int PR_W = NUM_W + M_W;

   localparam logic [CMP_W-1:0] FS_C = CMP_W'(FS);
   localparam logic [CMP_W-1:0] LOW_LIM = CMP_W'(3 * FS);
   localparam logic [CMP_W-1:0] HIGH_LIM = CMP_W'(21 * FS);

   logic             v1_ff;
   logic [ADC_W-1:0] adc1_ff;
   logic [ACT_W-1:0] comms1_ff;
   logic             startup1_ff, lost1_ff;

   logic [CMP_W-1:0] adc_x, adc5, adc20;
   logic [NUM_W-1:0] num;
   logic [PR_W-1:0]  prod;

   assign in_ready = !v1_ff || out_ready;
   assign out_valid = v1_ff;

   // Loop limits, the numerator above the live zero and its scaled quotient.
   always_comb begin
      adc_x = CMP_W'(adc1_ff);
      adc5 = adc_x * CMP_W'(5);
      adc20 = adc_x * CMP_W'(20);
      out_tick.loop_low = adc20 <= LOW_LIM;
      out_tick.loop_high = adc20 >= HIGH_LIM;
      out_tick.ana_ok = adc_x <= FS_C;
      out_tick.comms_ok = comms1_ff <= ACT_W'(AS);
      out_tick.comms = comms1_ff;
      out_tick.startup = startup1_ff;
      out_tick.lost = lost1_ff;
      if (out_tick.ana_ok && adc5 > FS_C) begin
         num = NUM_W'(adc5 - FS_C);
      end else begin
         num = '0;
      end
      prod = PR_W'(num) * PR_W'(MUL);
      out_tick.ana_val = ACT_W'(prod >> SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (in_ready) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         adc1_ff <= in_adc;
         comms1_ff <= in_comms;
         startup1_ff <= in_startup;
         lost1_ff <= in_lost;
      end
   end

endmodule

// ----- rtl/loop_current_level_alarm_monitor.sv -----
// An input transfer passes through the input register, then the result register,
// before its result can transfer out.
// Throughput: one item per cycle; the result register is also the monitor state.
// A stalled result holds the input register, and the input stalls once both are full.
// Reset is synchronous: it empties both registers, clears all fault and alarm state,
// and returns the registers to their defaults.
module loop_current_level_alarm_monitor #(
   parameter int FULL_SCALE_CODE = lcam_pkg::DEFAULT_FULL_SCALE_CODE,
   parameter int ACTIVITY_SCALE = lcam_pkg::DEFAULT_ACTIVITY_SCALE
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [lcam_pkg::ADC_W-1:0]       req_adc_sample,
   input  logic [lcam_pkg::ACT_W-1:0]       req_comms_activity,
   input  logic                             req_startup_active,
   input  logic                             req_comms_lost,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [lcam_pkg::ACT_W-1:0]       rsp_activity_out,
   output logic [1:0]                       rsp_activity_kind,
   output logic                             rsp_level_alarm,
   output logic                             rsp_upper_alarm,
   output logic                             rsp_comms_alarm,
   output logic                             rsp_out_of_range,
   output logic                             rsp_input_low,
   output logic                             rsp_input_high,
   input  logic                             csr_write_en,
   input  logic [lcam_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lcam_pkg::CSR_W-1:0]       csr_wdata
);
   import lcam_pkg::*;

   logic [MODE_W-1:0] mode_ff;
   logic              mask_ff;
   logic [ACT_W-1:0]  level_ff, upper_ff, hyst_ff;

   logic             rsp_valid_ff;
   logic             range_ff, low_ff, high_ff, first_ff, second_ff, link_ff;
   logic [ACT_W-1:0] held_ff;
   kind_type         kind_ff;

   logic             range_in, low_in, high_in, first_in, second_in, link_in;
   logic [ACT_W-1:0] held_in;
   kind_type         kind_in;

   logic     scale_ready, tick_valid, out_en, take;
   tick_type tick;
   logic     lost, valid, is_off, is_analog;
   logic [ACT_W-1:0] val;

   function automatic logic level_latch(input logic latch, input logic [ACT_W-1:0] value,
                                        input logic [ACT_W-1:0] thr,
                                        input logic [ACT_W-1:0] hyst);
      logic result;
      result = latch;
      if (value >= thr) begin
         result = 1'b1;
      end else if ({1'b0, value} + {1'b0, hyst} < {1'b0, thr}) begin
         result = 1'b0;
      end
      return result;
   endfunction

   lcam_scale #(
      .FULL_SCALE_CODE(FULL_SCALE_CODE),
      .ACTIVITY_SCALE(ACTIVITY_SCALE)
   ) u_scale (
      .clock(clock),
      .reset(reset),
      .in_valid(req_valid),
      .in_ready(scale_ready),
      .in_adc(req_adc_sample),
      .in_comms(req_comms_activity),
      .in_startup(req_startup_active),
      .in_lost(req_comms_lost),
      .out_valid(tick_valid),
      .out_ready(out_en),
      .out_tick(tick)
   );

   assign out_en = !rsp_valid_ff || !rsp_stall;
   assign take = tick_valid && out_en;
   assign req_stall = !scale_ready;

   // Next monitor state for the sample held in the input register.
   always_comb begin
      range_in = range_ff;
      low_in = low_ff;
      high_in = high_ff;
      first_in = first_ff;
      second_in = second_ff;
      link_in = link_ff;
      held_in = held_ff;
      kind_in = kind_ff;
      lost = tick.lost;
      is_off = mode_ff == MODE_OFF;
      is_analog = mode_ff == MODE_ANALOG;

      if (is_analog && !tick.startup) begin
         if (tick.loop_low || tick.loop_high) begin
            if (tick.loop_low) begin
               low_in = 1'b1;
               held_in = '0;
               kind_in = KIND_LOW;
            end
            if (tick.loop_high) begin
               high_in = 1'b1;
               held_in = '0;
               kind_in = KIND_HIGH;
            end
            range_in = 1'b1;
         end else if (range_in) begin
            // Recovery from a loop fault ignores a link loss on the same sample.
            range_in = 1'b0;
            low_in = 1'b0;
            high_in = 1'b0;
            lost = 1'b0;
         end
      end
      if (is_off && !tick.startup && range_in) begin
         range_in = 1'b0;
         low_in = 1'b0;
         high_in = 1'b0;
         link_in = 1'b0;
      end

      if (is_analog) begin
         valid = !low_in && !high_in && tick.ana_ok;
         val = tick.ana_val;
      end else if (!is_off) begin
         valid = tick.comms_ok;
         val = tick.comms;
      end else begin
         valid = 1'b0;
         val = '0;
      end

      if (!is_off && !link_in) begin
         if (valid) begin
            range_in = 1'b0;
            held_in = val;
            kind_in = KIND_VALUE;
         end else begin
            range_in = 1'b1;
         end
      end
      if (is_off) begin
         held_in = '0;
         kind_in = KIND_VALUE;
      end

      if (!is_off && !mask_ff && !link_in) begin
         if (kind_in == KIND_VALUE) begin
            first_in = level_latch(first_in, held_in, level_ff, hyst_ff);
            second_in = level_latch(second_in, held_in, upper_ff, hyst_ff);
         end
      end else begin
         first_in = 1'b0;
         second_in = 1'b0;
      end

      if (!is_off && !mask_ff) begin
         if (lost) begin
            if (!link_in) begin
               link_in = 1'b1;
               held_in = '0;
               kind_in = KIND_COMMS;
            end
         end else begin
            link_in = 1'b0;
         end
      end else if (link_in) begin
         range_in = 1'b0;
         low_in = 1'b0;
         high_in = 1'b0;
         link_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_OFF;
         mask_ff <= 1'b0;
         level_ff <= LEVEL_RESET;
         upper_ff <= LEVEL_RESET;
         hyst_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SENSOR_MODE: mode_ff <= csr_wdata[MODE_W-1:0];
            CSR_ALARM_MASK:  mask_ff <= csr_wdata[0];
            CSR_ALARM_LEVEL: level_ff <= csr_wdata[ACT_W-1:0];
            CSR_UPPER_LEVEL: upper_ff <= csr_wdata[ACT_W-1:0];
            CSR_HYSTERESIS:  hyst_ff <= csr_wdata[ACT_W-1:0];
            default: ;
         endcase
      end
   end

   // The result register holds the monitor state; it only moves when it takes a sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         range_ff <= 1'b0;
         low_ff <= 1'b0;
         high_ff <= 1'b0;
         first_ff <= 1'b0;
         second_ff <= 1'b0;
         link_ff <= 1'b0;
         held_ff <= '0;
         kind_ff <= KIND_VALUE;
      end else begin
         if (out_en) rsp_valid_ff <= tick_valid;
         if (take) begin
            range_ff <= range_in;
            low_ff <= low_in;
            high_ff <= high_in;
            first_ff <= first_in;
            second_ff <= second_in;
            link_ff <= link_in;
            held_ff <= held_in;
            kind_ff <= kind_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_activity_out = held_ff;
   assign rsp_activity_kind = kind_ff;
   assign rsp_level_alarm = first_ff;
   assign rsp_upper_alarm = second_ff;
   assign rsp_comms_alarm = link_ff;
   assign rsp_out_of_range = range_ff;
   assign rsp_input_low = low_ff;
   assign rsp_input_high = high_ff;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the loop current level alarm monitor.
`timescale 1ns / 1ps

module tb_top;
   import lcam_pkg::*;

   localparam int FS = DEFAULT_FULL_SCALE_CODE;
   localparam int SCALE = DEFAULT_ACTIVITY_SCALE;
   localparam int LOOP_SPAN_MA = 20;
   localparam int LOOP_LOW_MA = 3;
   localparam int LOOP_HIGH_MA = 21;
   // 20 mA full scale over the 4 mA live zero.
   localparam int ZERO_RATIO = 5;
   localparam int PIPE_LATENCY = 2;
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam logic [CSR_W-1:0] CSR_ALL_ONES = '1;

   typedef struct {
      logic [ADC_W-1:0] adc;
      logic [ACT_W-1:0] comms;
      logic             startup;
      logic             lost;
   } reading_t;

   typedef struct {
      logic [ACT_W-1:0] activity;
      kind_type         kind;
      logic             level;
      logic             upper;
      logic             link;
      logic             range;
      logic             in_low;
      logic             in_high;
   } alarm_word_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [ADC_W-1:0] req_adc_sample = '0;
   logic [ACT_W-1:0] req_comms_activity = '0;
   logic req_startup_active = 1'b0;
   logic req_comms_lost = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ACT_W-1:0] rsp_activity_out;
   logic [1:0] rsp_activity_kind;
   logic rsp_level_alarm;
   logic rsp_upper_alarm;
   logic rsp_comms_alarm;
   logic rsp_out_of_range;
   logic rsp_input_low;
   logic rsp_input_high;
   logic csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   loop_current_level_alarm_monitor dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_adc_sample(req_adc_sample),
      .req_comms_activity(req_comms_activity),
      .req_startup_active(req_startup_active),
      .req_comms_lost(req_comms_lost),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_activity_out(rsp_activity_out),
      .rsp_activity_kind(rsp_activity_kind),
      .rsp_level_alarm(rsp_level_alarm),
      .rsp_upper_alarm(rsp_upper_alarm),
      .rsp_comms_alarm(rsp_comms_alarm),
      .rsp_out_of_range(rsp_out_of_range),
      .rsp_input_low(rsp_input_low),
      .rsp_input_high(rsp_input_high),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   reading_t pending_readings[$];
   alarm_word_t expected_words[$];
   int errors = 0;
   bit idle_on = 1'b1;
   int unsigned sent_cnt = 0;
   int unsigned taken_cnt = 0;
   int unsigned rsp_seen = 0;
   int unsigned rsp_drawn = 0;
   int unsigned req_gap = 0;
   int unsigned rsp_hold = 0;

   // Predictor copy of the configuration and the monitor state.
   logic [MODE_W-1:0] cfg_mode;
   logic cfg_mask;
   logic [ACT_W-1:0] cfg_level, cfg_upper, cfg_hyst;
   logic range_flt = 1'b0, low_flt = 1'b0, high_flt = 1'b0;
   logic level_lt = 1'b0, upper_lt = 1'b0, link_lt = 1'b0;
   logic [ACT_W-1:0] held_act = '0;
   kind_type held_kind = KIND_VALUE;

   // Random walk state for the well-formed part of the stimulus.
   int walk_adc = 2000;
   int walk_comms = 5000;
   int lost_left = 0;

   function automatic logic hold_level(logic latch, logic [ACT_W-1:0] act,
                                       logic [ACT_W-1:0] thr);
      int lower;
      lower = int'(thr) - int'(cfg_hyst);
      if (act >= thr) return 1'b1;
      if (int'(act) < lower) return 1'b0;
      return latch;
   endfunction

   task automatic clear_faults();
      range_flt = 1'b0;
      low_flt = 1'b0;
      high_flt = 1'b0;
      link_lt = 1'b0;
   endtask

   task automatic advance_monitor(input reading_t r);
      alarm_word_t w;
      logic lost;
      logic act_ok;
      int adc, num, act;
      adc = int'(r.adc);
      lost = r.lost;
      act_ok = 1'b0;
      act = 0;

      if (cfg_mode == MODE_ANALOG && !r.startup) begin
         if (adc * LOOP_SPAN_MA <= FS * LOOP_LOW_MA ||
             adc * LOOP_SPAN_MA >= FS * LOOP_HIGH_MA) begin
            if (adc * LOOP_SPAN_MA <= FS * LOOP_LOW_MA) begin
               low_flt = 1'b1;
               held_act = '0;
               held_kind = KIND_LOW;
            end
            if (adc * LOOP_SPAN_MA >= FS * LOOP_HIGH_MA) begin
               high_flt = 1'b1;
               held_act = '0;
               held_kind = KIND_HIGH;
            end
            range_flt = 1'b1;
         end else if (range_flt) begin
            // Recovery from a loop fault ignores a link loss on this tick.
            range_flt = 1'b0;
            low_flt = 1'b0;
            high_flt = 1'b0;
            lost = 1'b0;
         end
      end
      if (cfg_mode == MODE_OFF && !r.startup && range_flt) clear_faults();

      if (cfg_mode == MODE_ANALOG) begin
         if (!low_flt && !high_flt) begin
            if (adc * ZERO_RATIO <= FS) begin
               act_ok = 1'b1;
            end else begin
               num = adc * ZERO_RATIO - FS;
               act_ok = num <= FS * 4;
               if (act_ok) act = (num * SCALE) / (FS * 4);
            end
         end
      end else if (cfg_mode != MODE_OFF) begin
         act_ok = int'(r.comms) <= SCALE;
         act = int'(r.comms);
      end

      if (cfg_mode != MODE_OFF && !link_lt) begin
         if (act_ok) begin
            range_flt = 1'b0;
            held_act = ACT_W'(act);
            held_kind = KIND_VALUE;
         end else begin
            range_flt = 1'b1;
         end
      end
      if (cfg_mode == MODE_OFF) begin
         held_act = '0;
         held_kind = KIND_VALUE;
      end

      if (cfg_mode != MODE_OFF && !cfg_mask && !link_lt) begin
         if (held_kind == KIND_VALUE) begin
            level_lt = hold_level(level_lt, held_act, cfg_level);
            upper_lt = hold_level(upper_lt, held_act, cfg_upper);
         end
      end else begin
         level_lt = 1'b0;
         upper_lt = 1'b0;
      end

      if (cfg_mode != MODE_OFF && !cfg_mask) begin
         if (lost) begin
            if (!link_lt) begin
               link_lt = 1'b1;
               held_act = '0;
               held_kind = KIND_COMMS;
            end
         end else begin
            link_lt = 1'b0;
         end
      end else if (link_lt) begin
         clear_faults();
      end

      w.activity = held_act;
      w.kind = held_kind;
      w.level = level_lt;
      w.upper = upper_lt;
      w.link = link_lt;
      w.range = range_flt;
      w.in_low = low_flt;
      w.in_high = high_flt;
      expected_words.push_back(w);
   endtask

   task automatic check_field(input string name, input logic [ACT_W-1:0] want,
                              input logic [ACT_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // Input side: note each transfer and predict its result.
   always @(posedge clock) begin
      reading_t r;
      if (!reset && req_valid && !req_stall) begin
         r.adc = req_adc_sample;
         r.comms = req_comms_activity;
         r.startup = req_startup_active;
         r.lost = req_comms_lost;
         advance_monitor(r);
         taken_cnt++;
      end
   end

   always @(negedge clock) begin
      reading_t r;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (taken_cnt == sent_cnt) begin
         if (req_gap != 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_readings.size() != 0) begin
            r = pending_readings.pop_front();
            req_adc_sample <= r.adc;
            req_comms_activity <= r.comms;
            req_startup_active <= r.startup;
            req_comms_lost <= r.lost;
            req_valid <= 1'b1;
            sent_cnt++;
            req_gap = idle_on ? $urandom_range(0, 3) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side: compare each transfer with the oldest prediction.
   always @(posedge clock) begin
      alarm_word_t w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $display("%0t: result with nothing expected, activity %0d kind %0d", $time,
                     rsp_activity_out, rsp_activity_kind);
            errors++;
         end else begin
            w = expected_words.pop_front();
            check_field("activity_out", w.activity, rsp_activity_out);
            check_field("activity_kind", ACT_W'(w.kind), ACT_W'(rsp_activity_kind));
            check_field("level_alarm", ACT_W'(w.level), ACT_W'(rsp_level_alarm));
            check_field("upper_alarm", ACT_W'(w.upper), ACT_W'(rsp_upper_alarm));
            check_field("comms_alarm", ACT_W'(w.link), ACT_W'(rsp_comms_alarm));
            check_field("out_of_range", ACT_W'(w.range), ACT_W'(rsp_out_of_range));
            check_field("input_low", ACT_W'(w.in_low), ACT_W'(rsp_input_low));
            check_field("input_high", ACT_W'(w.in_high), ACT_W'(rsp_input_high));
         end
         rsp_seen++;
      end
   end

   // After each result transfer, draw how long the receiver holds off.
   always @(negedge clock) begin
      if (rsp_drawn != rsp_seen) begin
         rsp_drawn = rsp_seen;
         rsp_hold = idle_on ? $urandom_range(0, 3) : 0;
      end
      if (rsp_hold != 0) begin
         rsp_stall <= 1'b1;
         rsp_hold--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      case (idx)
         CSR_SENSOR_MODE: cfg_mode = data[MODE_W-1:0];
         CSR_ALARM_MASK: cfg_mask = data[0];
         CSR_ALARM_LEVEL: cfg_level = data;
         CSR_UPPER_LEVEL: cfg_upper = data;
         CSR_HYSTERESIS: cfg_hyst = data;
         default: ;
      endcase
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic set_config(input logic [MODE_W-1:0] mode, input logic mask,
                             input int level, input int upper, input int hyst);
      write_reg(CSR_SENSOR_MODE, CSR_W'(mode));
      write_reg(CSR_ALARM_MASK, CSR_W'(mask));
      write_reg(CSR_ALARM_LEVEL, CSR_W'(level));
      write_reg(CSR_UPPER_LEVEL, CSR_W'(upper));
      write_reg(CSR_HYSTERESIS, CSR_W'(hyst));
   endtask

   // Hold the sender until the block has returned every result.
   task automatic drain();
      do begin
         @(posedge clock);
         #1;
      end while (pending_readings.size() != 0 || req_valid || expected_words.size() != 0);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic add_reading(input int adc, input int comms, input bit startup, input bit lost);
      reading_t r;
      r.adc = ADC_W'(adc);
      r.comms = ACT_W'(comms);
      r.startup = startup;
      r.lost = lost;
      pending_readings.push_back(r);
   endtask

   function automatic int pick_threshold();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return SCALE;
         2: return int'(CSR_ALL_ONES);
         default: return $urandom_range(0, SCALE);
      endcase
   endfunction

   function automatic int walk_step(int pos, int span, int top);
      pos = pos + $urandom_range(0, 2 * span) - span;
      if (pos < 0) pos = 0;
      if (pos > top) pos = top;
      return pos;
   endfunction

   // Mostly slow walks with short link-loss bursts, plus a little noise.
   task automatic queue_walk(input int count);
      int startup_left;
      startup_left = $urandom_range(0, 4);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 31) == 0) begin
            add_reading($urandom_range(0, 4095), $urandom_range(0, 16383),
                        $urandom_range(0, 1), $urandom_range(0, 1));
         end else begin
            if ($urandom_range(0, 15) == 0) begin
               walk_adc = $urandom_range(0, 4095);
               walk_comms = $urandom_range(0, 16383);
            end else begin
               walk_adc = walk_step(walk_adc, 300, 4095);
               walk_comms = walk_step(walk_comms, 700, 16383);
            end
            if (lost_left == 0 && $urandom_range(0, 39) == 0) lost_left = $urandom_range(1, 5);
            add_reading(walk_adc, walk_comms, startup_left != 0, lost_left != 0);
            if (lost_left != 0) lost_left--;
            if (startup_left != 0) startup_left--;
         end
      end
   endtask

   initial begin
      int pick;
      cfg_mode = MODE_OFF;
      cfg_mask = 1'b0;
      cfg_level = LEVEL_RESET;
      cfg_upper = LEVEL_RESET;
      cfg_hyst = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: the block is disabled and reports zero activity with no alarms.
      add_reading(0, 0, 1'b0, 1'b0);
      add_reading(4095, 16383, 1'b1, 1'b1);
      drain();

      // Analogue loop: under-range, live zero, full scale, hysteresis, link loss.
      set_config(MODE_ANALOG, 1'b0, 5000, 9000, 1000);
      add_reading(0, 0, 1'b1, 1'b0);
      add_reading(0, 0, 1'b0, 1'b0);
      add_reading(614, 0, 1'b0, 1'b0);
      add_reading(615, 0, 1'b0, 1'b1);
      add_reading(819, 0, 1'b0, 1'b0);
      add_reading(820, 0, 1'b0, 1'b0);
      add_reading(3300, 0, 1'b0, 1'b0);
      add_reading(4095, 16383, 1'b0, 1'b0);
      add_reading(3900, 0, 1'b0, 1'b0);
      add_reading(3000, 0, 1'b0, 1'b0);
      add_reading(2000, 0, 1'b0, 1'b0);
      add_reading(2500, 0, 1'b0, 1'b1);
      add_reading(2500, 0, 1'b0, 1'b1);
      add_reading(2500, 0, 1'b0, 1'b0);
      add_reading(100, 0, 1'b0, 1'b0);
      drain();

      // Disabling with a loop fault still set clears the faults.
      write_reg(CSR_SENSOR_MODE, CSR_W'(MODE_OFF));
      add_reading(100, 0, 1'b0, 1'b0);
      drain();

      // Digital value: zero and full thresholds, out-of-range comms, link loss.
      set_config(MODE_DIGITAL, 1'b0, 0, 10000, 10000);
      add_reading(0, 0, 1'b0, 1'b0);
      add_reading(0, 10000, 1'b0, 1'b0);
      add_reading(0, 10001, 1'b0, 1'b0);
      add_reading(0, 16383, 1'b0, 1'b0);
      add_reading(0, 5000, 1'b0, 1'b1);
      add_reading(0, 5000, 1'b0, 1'b1);
      add_reading(0, 5000, 1'b0, 1'b0);
      drain();

      // The spare mode code acts as digital; masking stops alarms and link loss.
      set_config(MODE_SPARE, 1'b1, 0, 0, 0);
      add_reading(0, 7000, 1'b0, 1'b0);
      add_reading(0, 7000, 1'b0, 1'b1);
      drain();

      // Writes beyond the register list must have no effect.
      for (int i = int'(CSR_HYSTERESIS) + 1; i < (1 << CSR_INDEX_W); i++)
         write_reg(CSR_INDEX_W'(i), CSR_ALL_ONES);
      add_reading(0, 9000, 1'b0, 1'b1);
      drain();

      for (int phase = 0; phase < 14; phase++) begin
         pick = $urandom_range(0, 7);
         set_config(pick == 0 ? MODE_OFF : pick < 4 ? MODE_DIGITAL :
                    pick < 7 ? MODE_ANALOG : MODE_SPARE,
                    $urandom_range(0, 5) == 0, pick_threshold(), pick_threshold(),
                    $urandom_range(0, 3) == 0 ? pick_threshold() : $urandom_range(0, 2500));
         idle_on = $urandom_range(0, 3) != 0;
         queue_walk($urandom_range(100, 140));
         drain();
      end

      if (errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/lcam_pkg.sv
rtl/lcam_scale.sv
rtl/loop_current_level_alarm_monitor.sv
tb/tb_top.sv
